// File: design/dssa_pkg.sv
`default_nettype none

package dssa_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned STATUS_W = 2;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [WORD_W-1:0]   word_t;

    localparam cmd_t CMD_PUSH = 2'd0;
    localparam cmd_t CMD_POP  = 2'd1;
    localparam cmd_t CMD_PEEK = 2'd2;
    localparam cmd_t CMD_DUMP = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_OVER  = 2'd1;
    localparam status_t ST_UNDER = 2'd2;

endpackage

`default_nettype wire

// File: design/dual_stack_shared_array_unit.sv
// Two LIFO stacks in one store of DEPTH words: stack 0 grows up from entry 0,
// stack 1 grows down from entry DEPTH-1.
// Command beats arrive on the s_axis channel: tuser carries cmd (push, pop,
// peek, dump) and stack_sel, tdata the word to push. Results leave on the
// m_axis channel: tdata is the word read, tuser the status (ok, overflow,
// underflow), tlast marks the final result of a command.
// One command is worked at a time; s_axis_tready is high only while idle.
// Each step goes through one shared address unit and the single store port.
// Push, or any command that underflows: from EXEC the result goes to OUT.
// Pop and peek: EXEC, then RD (registered store read), then the result in OUT.
// Dump of n entries: n results, each through EXEC, RD and OUT; once a result
// that is not the last is taken, the next entry starts again at EXEC. Idle
// again in the cycle after the final result beat is taken.
// When the receiver stalls, the result holds on m_axis and nothing else moves.
// Reset empties both stacks; the store itself is not cleared, and only entries
// written by a push are ever read.
`default_nettype none

module dual_stack_shared_array_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // push_value
    input  wire logic [2:0]  s_axis_tuser,   // cmd[1:0], stack_sel[2]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // read_value
    output logic [1:0]       m_axis_tuser,   // status[1:0]
    output logic             m_axis_tlast    // last
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned AW = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    dssa_pkg::cmd_t   cmd_reg, cmd_next;
    logic             sel_reg, sel_next;
    dssa_pkg::word_t  val_reg, val_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [CW-1:0]    low_reg, low_next;
    logic [CW-1:0]    high_reg, high_next;
    dssa_pkg::word_t  data_reg, data_next;
    dssa_pkg::status_t status_reg, status_next;
    logic             last_reg, last_next;

    dssa_pkg::word_t  mem [DEPTH];
    dssa_pkg::word_t  rdata_reg;
    logic             mem_we;
    logic [CW-1:0]    offset;
    logic [AW-1:0]    addr;
    logic [CW:0]      fill;
    logic             full;

    // shared address unit
    assign offset = (cmd_reg == dssa_pkg::CMD_PUSH) ? pos_reg : pos_reg - CW'(1);
    assign addr   = sel_reg ? (AW'(DEPTH - 1) - offset[AW-1:0]) : offset[AW-1:0];
    assign fill   = {1'b0, low_reg} + {1'b0, high_reg};
    assign full   = fill >= (CW+1)'(DEPTH);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tlast  = last_reg;

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        sel_next    = sel_reg;
        val_next    = val_reg;
        pos_next    = pos_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        data_next   = data_reg;
        status_next = status_reg;
        last_next   = last_reg;
        mem_we      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd_next   = s_axis_tuser[1:0];
                    sel_next   = s_axis_tuser[2];
                    val_next   = s_axis_tdata;
                    pos_next   = s_axis_tuser[2] ? high_reg : low_reg;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (cmd_reg == dssa_pkg::CMD_PUSH) begin
                    data_next   = '0;
                    last_next   = 1'b1;
                    state_next  = S_OUT;
                    if (full) begin
                        status_next = dssa_pkg::ST_OVER;
                    end else begin
                        status_next = dssa_pkg::ST_OK;
                        mem_we      = 1'b1;
                        if (sel_reg) begin
                            high_next = high_reg + CW'(1);
                        end else begin
                            low_next = low_reg + CW'(1);
                        end
                    end
                end else if (pos_reg == '0) begin
                    data_next   = '1;
                    status_next = dssa_pkg::ST_UNDER;
                    last_next   = 1'b1;
                    state_next  = S_OUT;
                end else begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                data_next   = rdata_reg;
                status_next = dssa_pkg::ST_OK;
                last_next   = (cmd_reg != dssa_pkg::CMD_DUMP) || (pos_reg == CW'(1));
                if (cmd_reg == dssa_pkg::CMD_POP) begin
                    if (sel_reg) begin
                        high_next = pos_reg - CW'(1);
                    end else begin
                        low_next = pos_reg - CW'(1);
                    end
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    if ((cmd_reg == dssa_pkg::CMD_DUMP) && !last_reg) begin
                        pos_next   = pos_reg - CW'(1);
                        state_next = S_EXEC;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            low_reg   <= '0;
            high_reg  <= '0;
        end else begin
            state_reg <= state_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
        end
        cmd_reg    <= cmd_next;
        sel_reg    <= sel_next;
        val_reg    <= val_next;
        pos_reg    <= pos_next;
        data_reg   <= data_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr] <= val_reg;
        end
        rdata_reg <= mem[addr];
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, low_reg} + {1'b0, high_reg}) <= (CW+1)'(DEPTH))
        else $error("stack counts exceed store depth");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("command accepted while a result is pending");

    a_underflow_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == dssa_pkg::ST_UNDER))
            |-> ((m_axis_tdata == '1) && m_axis_tlast))
        else $error("underflow result not all ones or not last");

    a_overflow_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_EXEC) && (cmd_reg == dssa_pkg::CMD_PUSH) && full)
            |=> (m_axis_tvalid && (m_axis_tuser == dssa_pkg::ST_OVER)))
        else $error("push to full store did not report overflow");

endmodule

`default_nettype wire

// File: tb/sv/dual_stack_shared_array_unit_test.sv
`default_nettype none

module dual_stack_shared_array_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_DEPTH = 16;
    localparam int unsigned RANDOM_CHUNKS = 8;
    localparam int unsigned CHUNK_ITEMS = 43;
    localparam int unsigned PLAN_ROWS = 14;

    typedef struct packed {
        dssa_pkg::word_t   value;
        dssa_pkg::status_t status;
        logic              last;
    } stack_result_t;

    typedef struct {
        dssa_pkg::cmd_t    op;
        logic              sel;
        dssa_pkg::word_t   value;
        int                reps;
        bit                typed;
        dssa_pkg::word_t   t_value;
        dssa_pkg::status_t t_status;
    } plan_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // push_value
    logic [2:0]  s_axis_tuser = '0;   // cmd[1:0], stack_sel[2]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // read_value
    logic [1:0]  m_axis_tuser;        // status[1:0]
    logic        m_axis_tlast;        // last

    // shadow copy of the stack pair
    dssa_pkg::word_t shadow_store [STORE_DEPTH];
    int unsigned     up_count = 0;
    int unsigned     down_count = 0;

    stack_result_t step_results [$];
    stack_result_t expected_results [$];
    stack_result_t want;

    bit          calm = 1'b0;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          stall_left = 0;
    int          fail_count = 0;
    int          beats_seen = 0;
    int          commands_done = 0;
    int          overflow_hits = 0;
    int          underflow_hits = 0;
    int          longest_dump = 0;

    // extremes first, then fill both stacks until the store is full, overflow it once and dump both stacks
    plan_row_t plan [PLAN_ROWS] = '{
        '{dssa_pkg::CMD_POP,  1'b0, 32'h0000_0000, 1, 1'b1, 32'hFFFF_FFFF, dssa_pkg::ST_UNDER},
        '{dssa_pkg::CMD_PEEK, 1'b1, 32'h0000_0000, 1, 1'b1, 32'hFFFF_FFFF, dssa_pkg::ST_UNDER},
        '{dssa_pkg::CMD_DUMP, 1'b0, 32'h0000_0000, 1, 1'b1, 32'hFFFF_FFFF, dssa_pkg::ST_UNDER},
        '{dssa_pkg::CMD_PUSH, 1'b0, 32'h7FFF_FFFF, 1, 1'b1, 32'h0000_0000, dssa_pkg::ST_OK},
        '{dssa_pkg::CMD_PUSH, 1'b1, 32'h8000_0000, 1, 1'b1, 32'h0000_0000, dssa_pkg::ST_OK},
        '{dssa_pkg::CMD_PUSH, 1'b0, 32'h0000_0000, 1, 1'b1, 32'h0000_0000, dssa_pkg::ST_OK},
        '{dssa_pkg::CMD_PUSH, 1'b1, 32'hFFFF_FFFF, 1, 1'b1, 32'h0000_0000, dssa_pkg::ST_OK},
        '{dssa_pkg::CMD_PEEK, 1'b0, 32'h0000_0000, 1, 1'b1, 32'h0000_0000, dssa_pkg::ST_OK},
        '{dssa_pkg::CMD_POP,  1'b1, 32'h0000_0000, 1, 1'b1, 32'hFFFF_FFFF, dssa_pkg::ST_OK},
        '{dssa_pkg::CMD_PUSH, 1'b0, 32'hA5A5_0000, 7, 1'b1, 32'h0000_0000, dssa_pkg::ST_OK},
        '{dssa_pkg::CMD_PUSH, 1'b1, 32'h5A5A_0000, 6, 1'b1, 32'h0000_0000, dssa_pkg::ST_OK},
        '{dssa_pkg::CMD_PUSH, 1'b1, 32'h1234_5678, 1, 1'b1, 32'h0000_0000, dssa_pkg::ST_OVER},
        '{dssa_pkg::CMD_DUMP, 1'b0, 32'h0000_0000, 1, 1'b0, 32'h0000_0000, dssa_pkg::ST_OK},
        '{dssa_pkg::CMD_DUMP, 1'b1, 32'h0000_0000, 1, 1'b0, 32'h0000_0000, dssa_pkg::ST_OK}
    };

    dual_stack_shared_array_unit #(
        .DEPTH(STORE_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned slot_index(logic sel, int unsigned pos);
        return sel ? STORE_DEPTH - 1 - pos : pos;
    endfunction

    function automatic void run_stack_op(dssa_pkg::cmd_t op, logic sel, dssa_pkg::word_t v);
        int unsigned held;
        int unsigned pos;
        step_results.delete();
        held = sel ? down_count : up_count;
        if (op == dssa_pkg::CMD_PUSH) begin
            if (up_count + down_count >= STORE_DEPTH) begin
                step_results.push_back('{value: '0, status: dssa_pkg::ST_OVER, last: 1'b1});
                overflow_hits++;
            end else begin
                shadow_store[slot_index(sel, held)] = v;
                if (sel) begin
                    down_count++;
                end else begin
                    up_count++;
                end
                step_results.push_back('{value: '0, status: dssa_pkg::ST_OK, last: 1'b1});
            end
        end else if (held == 0) begin
            step_results.push_back('{value: '1, status: dssa_pkg::ST_UNDER, last: 1'b1});
            underflow_hits++;
        end else if (op == dssa_pkg::CMD_DUMP) begin
            for (pos = held; pos > 0; pos--) begin
                step_results.push_back('{value: shadow_store[slot_index(sel, pos - 1)],
                                         status: dssa_pkg::ST_OK, last: (pos == 1)});
            end
            if (held > longest_dump) begin
                longest_dump = held;
            end
        end else begin
            step_results.push_back('{value: shadow_store[slot_index(sel, held - 1)],
                                     status: dssa_pkg::ST_OK, last: 1'b1});
            if (op == dssa_pkg::CMD_POP) begin
                if (sel) begin
                    down_count--;
                end else begin
                    up_count--;
                end
            end
        end
    endfunction

    task automatic issue_command(input dssa_pkg::cmd_t op, input logic sel,
                                 input dssa_pkg::word_t v, input bit typed,
                                 input dssa_pkg::word_t tv, input dssa_pkg::status_t ts);
        int gap;
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        s_axis_tuser <= {sel, op};
        do @(posedge aclk); while (!s_axis_tready);
        run_stack_op(op, sel, v);
        if (typed) begin
            expected_results.push_back('{value: tv, status: ts, last: 1'b1});
        end else begin
            foreach (step_results[i]) expected_results.push_back(step_results[i]);
        end
        commands_done++;
    endtask

    // result side: check each beat, stall in random bursts
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                beats_seen++;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result beat: data %h status %0d last %b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata !== want.value || m_axis_tuser !== want.status ||
                        m_axis_tlast !== want.last) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("beat %0d: expected %h/%0d/%b got %h/%0d/%b",
                                     beats_seen, want.value, want.status, want.last,
                                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 16);
            end
            m_axis_tready <= (stall_left == 0);
        end
    end

    initial begin
        int              row;
        int              k;
        int              chunk;
        int              pick;
        int              wait_cycles;
        bit              draining;
        int              sel_bias;
        dssa_pkg::cmd_t  op;
        logic            sel;
        dssa_pkg::word_t v;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (row = 0; row < PLAN_ROWS; row++) begin
            for (k = 0; k < plan[row].reps; k++) begin
                issue_command(plan[row].op, plan[row].sel, plan[row].value + k,
                              plan[row].typed, plan[row].t_value, plan[row].t_status);
            end
        end

        // alternate draining and filling, last chunk runs without idling
        for (chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            calm = (chunk == RANDOM_CHUNKS - 1);
            gap_pct = calm ? 0 : 15 * $urandom_range(0, 2);
            stall_pct = calm ? 0 : 15 * $urandom_range(0, 2);
            draining = (chunk % 2 == 0);
            sel_bias = $urandom_range(10, 90);
            for (k = 0; k < CHUNK_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < (draining ? 20 : 65)) begin
                    op = dssa_pkg::CMD_PUSH;
                end else if (pick < (draining ? 65 : 80)) begin
                    op = dssa_pkg::CMD_POP;
                end else if (pick < 92) begin
                    op = dssa_pkg::CMD_PEEK;
                end else begin
                    op = dssa_pkg::CMD_DUMP;
                end
                sel = ($urandom_range(0, 99) < sel_bias);
                case ($urandom_range(0, 7))
                    0: v = '0;
                    1: v = '1;
                    2: v = 32'h8000_0000;
                    3: v = 32'h7FFF_FFFF;
                    default: v = $urandom;
                endcase
                issue_command(op, sel, v, 1'b0, '0, dssa_pkg::ST_OK);
            end
        end
        s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < 2000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        if (expected_results.size() != 0) begin
            fail_count += expected_results.size();
            $display("%0d expected result beats never arrived", expected_results.size());
        end
        repeat (20) @(posedge aclk);

        $display("run covered %0d commands and %0d result beats", commands_done, beats_seen);
        $display("overflows %0d, underflows %0d, longest dump %0d entries",
                 overflow_hits, underflow_hits, longest_dump);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout waiting on the block");
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
